### rtl/core/thl_pkg.sv
// Shared widths, limits and register codes of the triplet hinge loss block.
package thl_pkg;

  localparam int VAL_W      = 16;
  localparam int DIFF_W     = VAL_W + 1;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 41;
  localparam int TOT_W      = 58;
  localparam int ADD_W      = TOT_W + 1;
  localparam int MARGIN_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [SUM_W-1:0]      SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [TOT_W-1:0]      TOT_MAX      = {TOT_W{1'b1}};
  localparam logic [MARGIN_W-1:0]   MARGIN_RESET = 32'd16777216;

  // register index decoded from the word address
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_MARGIN = 1'b0;

endpackage

### rtl/core/thl_ifs.sv
// Valid/ready channels of the triplet hinge loss block.
interface thl_in_if import thl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] anchor_value;
  logic signed [VAL_W-1:0] positive_value;
  logic signed [VAL_W-1:0] negative_value;
  logic                    last_channel;
  logic                    last_sample;

  modport source (
    output valid, anchor_value, positive_value, negative_value, last_channel, last_sample,
    input  ready
  );
  modport sink (
    input  valid, anchor_value, positive_value, negative_value, last_channel, last_sample,
    output ready
  );
endinterface

interface thl_out_if import thl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] sample_violation;
  logic             violation_active;
  logic [SUM_W-1:0] batch_loss;
  logic             loss_valid;

  modport source (
    output valid, sample_violation, violation_active, batch_loss, loss_valid,
    input  ready
  );
  modport sink (
    input  valid, sample_violation, violation_active, batch_loss, loss_valid,
    output ready
  );
endinterface

### rtl/core/thl_div.sv
// Restoring divider, one quotient bit per cycle, for the batch loss.
module thl_div import thl_pkg::*; #(
  parameter int DEN_W = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [TOT_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [TOT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(TOT_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [TOT_W-1:0]  quo_r;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_sub;
  logic              trial_ge;

  always_comb begin
    trial     = {rem_r, quo_r[TOT_W-1]};
    trial_ge  = trial >= {1'b0, den_r};
    trial_sub = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(TOT_W - 1);
        rem_r  <= '0;
        den_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        // dividend shifts out of the top while quotient bits shift in below
        quo_r <= {quo_r[TOT_W-2:0], trial_ge};
        rem_r <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/triplet_hinge_loss.sv
// Triplet hinge loss: squared distances, per-sample violation and batch loss.
//
// in_ch carries one feature channel of anchor, positive and negative (Q4.12)
// per beat, with last_channel / last_sample flags. out_ch gives one beat per
// finished sample: violation (Q17.24), its active flag, and on the batch's
// last sample the batch loss sum / (2 * samples) with loss_valid set.
// cfg is an APB write/read port holding the Q8.24 margin at address 0.
//
// One 17x17 squarer and one 59-bit adder are shared under the sequencer;
// in_ch.ready is high only while the sequencer is idle.
//   non-last channel : two squares, two accumulations per beat
//   last channel     : margin add, subtract, total, result registered at the end
//   last sample      : waits on the divider, which takes one quotient bit a cycle
// The output register decouples out_ch: a new beat is taken while a result
// waits; a stalled receiver holds the sequencer only when the next result
// is ready to be loaded.
// Reset clears the distance sums, the batch total and count, sets the
// margin to 1.0 and drops out_ch.valid.
module triplet_hinge_loss import thl_pkg::*; #(
  parameter int MAX_BATCH = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  thl_in_if.sink                in_ch,
  thl_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CNT_W = $clog2(MAX_BATCH + 1);
  localparam int DEN_W = CNT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_P, S_MUL_N, S_ACC_N, S_MARG, S_DIFF, S_TOT, S_DIV, S_EMIT
  } state_t;

  state_t                  state_r;
  logic signed [VAL_W-1:0] a_r, p_r, n_r;
  logic                    last_ch_r, last_smp_r;
  logic [SQ_W-1:0]         prod_r;
  logic [SUM_W-1:0]        pos_r, neg_r, viol_r, loss_r;
  logic [SUM_W:0]          tmp_r;
  logic [TOT_W-1:0]        total_r;
  logic [CNT_W-1:0]        count_r;
  logic [MARGIN_W-1:0]     margin_r;
  logic                    div_start_r;

  logic                    out_valid_r;
  logic [SUM_W-1:0]        out_viol_r, out_loss_r;
  logic                    out_active_r, out_loss_valid_r;

  logic signed [DIFF_W-1:0]   mul_d;
  logic signed [2*DIFF_W-1:0] mul_full;
  logic [ADD_W-1:0]           add_a, add_b;
  logic                       add_cin;
  logic [ADD_W:0]             add_s;
  logic [SUM_W-1:0]           sum_sat, viol_calc;
  logic [TOT_W-1:0]           tot_sat;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       in_fire, cfg_wr;
  logic                       div_done;
  logic [TOT_W-1:0]           div_quo;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;

  // shared squarer: positive channel first, negative next
  always_comb begin
    mul_d    = ((state_r == S_MUL_N) ? {n_r[VAL_W-1], n_r} : {p_r[VAL_W-1], p_r})
             - {a_r[VAL_W-1], a_r};
    mul_full = mul_d * mul_d;
  end

  // shared adder, operands picked by sequencer step
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state_r)
      S_MUL_N: begin
        add_a = ADD_W'(pos_r);
        add_b = ADD_W'(prod_r);
      end
      S_ACC_N: begin
        add_a = ADD_W'(neg_r);
        add_b = ADD_W'(prod_r);
      end
      S_MARG: begin
        add_a = ADD_W'(pos_r);
        add_b = ADD_W'(margin_r);
      end
      S_DIFF: begin
        add_a   = ADD_W'(tmp_r);
        add_b   = ~ADD_W'(neg_r);
        add_cin = 1'b1;
      end
      S_TOT: begin
        add_a = ADD_W'(total_r);
        add_b = ADD_W'(viol_r);
      end
      default: ;
    endcase
    add_s   = {1'b0, add_a} + {1'b0, add_b} + (ADD_W+1)'(add_cin);
    sum_sat = (|add_s[ADD_W:SUM_W]) ? SUM_MAX : add_s[SUM_W-1:0];
    tot_sat = (|add_s[ADD_W:TOT_W]) ? TOT_MAX : add_s[TOT_W-1:0];
    // carry out of the subtract means pos + margin >= neg
    if (!add_s[ADD_W])
      viol_calc = '0;
    else if (|add_s[ADD_W-1:SUM_W])
      viol_calc = SUM_MAX;
    else
      viol_calc = add_s[SUM_W-1:0];
    cnt_inc = (count_r < CNT_W'(MAX_BATCH)) ? count_r + 1'b1 : count_r;
  end

  thl_div #(.DEN_W(DEN_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (total_r),
    .divisor  ({count_r, 1'b0}),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      neg_r       <= '0;
      total_r     <= '0;
      count_r     <= '0;
      margin_r    <= MARGIN_RESET;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == S_TOT) && last_smp_r;
      // the emit step reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_EMIT)
        out_valid_r <= 1'b0;
      if (cfg_wr && cfg_paddr[CFG_ADDR_W-1:2] == CFG_IDX_MARGIN)
        margin_r <= cfg_pwdata;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            a_r        <= in_ch.anchor_value;
            p_r        <= in_ch.positive_value;
            n_r        <= in_ch.negative_value;
            last_ch_r  <= in_ch.last_channel;
            last_smp_r <= in_ch.last_sample;
            state_r    <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          prod_r  <= mul_full[SQ_W-1:0];
          state_r <= S_MUL_N;
        end
        S_MUL_N: begin
          pos_r   <= sum_sat;
          prod_r  <= mul_full[SQ_W-1:0];
          state_r <= S_ACC_N;
        end
        S_ACC_N: begin
          neg_r   <= sum_sat;
          state_r <= last_ch_r ? S_MARG : S_IDLE;
        end
        S_MARG: begin
          tmp_r   <= add_s[SUM_W:0];
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          viol_r  <= viol_calc;
          pos_r   <= '0;
          neg_r   <= '0;
          state_r <= S_TOT;
        end
        S_TOT: begin
          total_r <= tot_sat;
          count_r <= cnt_inc;
          state_r <= last_smp_r ? S_DIV : S_EMIT;
        end
        S_DIV: begin
          if (div_done) begin
            loss_r  <= (|div_quo[TOT_W-1:SUM_W]) ? SUM_MAX : div_quo[SUM_W-1:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r      <= 1'b1;
            out_viol_r       <= viol_r;
            out_active_r     <= (viol_r != '0);
            out_loss_r       <= last_smp_r ? loss_r : '0;
            out_loss_valid_r <= last_smp_r;
            if (last_smp_r) begin
              total_r <= '0;
              count_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.sample_violation = out_viol_r;
  assign out_ch.violation_active = out_active_r;
  assign out_ch.batch_loss       = out_loss_r;
  assign out_ch.loss_valid       = out_loss_valid_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == CFG_IDX_MARGIN) ? margin_r : '0;

  a_active_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_active_r == (out_viol_r != '0)))
    else $error("violation_active disagrees with sample_violation");

  a_loss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_loss_valid_r) |-> (out_loss_r == '0))
    else $error("batch_loss nonzero on a non-final sample");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BATCH))
    else $error("sample count beyond batch limit");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> (count_r != '0 && state_r == S_DIV))
    else $error("divider started with zero divisor or outside divide step");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_MUL_P && !in_ch.ready))
    else $error("sequencer did not leave idle after an accepted beat");

endmodule
